// ===== rtl/core/circle_nms_center_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Circle NMS assertion macros
// Short forms for the concurrent checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_NMS_CENTER_DISTANCE_MACROS_SVH
`define CIRCLE_NMS_CENTER_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define CNMS_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cnms_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle NMS package
// Shared widths, defaults, register codes and types of the circle NMS block.
// ----------------------------------------------------------------------------
package cnms_pkg;

    localparam int DEF_MAX_KEPT   = 512;
    localparam int DEF_MAX_BOXES  = 4096;
    localparam int DEF_COORD_BITS = 16;

    localparam int IN_COORD_W      = 16;
    localparam int THRESH_W        = 33;
    localparam int MAXK_W          = 10;
    localparam int INDEX_W         = 12;
    localparam int COUNT_W         = 10;
    localparam int INDEX_FIELD_MAX = 4095;

    localparam int S_TDATA_W = 2 * IN_COORD_W;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 64;

    localparam logic [MAXK_W-1:0] MAXK_RESET = 10'd512;

    // Register select: address bit 3 picks the 8-byte register slot.
    typedef enum logic {
        REG_THRESH = 1'b0,
        REG_MAXK   = 1'b1
    } cnms_reg_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } cnms_rsp_t;

    function automatic int cnms_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int cnms_min(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/core/circle_nms_center_distance.sv =====
// ----------------------------------------------------------------------------
// Circle NMS on box centers
// Suppresses boxes whose center lies within a squared distance of a kept one.
// ----------------------------------------------------------------------------
// Boxes enter on the s_ stream, sorted by descending score, one word per box:
// x in the low half of s_tdata, y in the high half, s_tlast on the last box
// of a list. Each box yields one word on the m_ stream with the kept flag,
// the box index and the running kept count; m_tlast echoes s_tlast and the
// kept count and index restart after that word.
// The APB port holds the squared-distance threshold (offset 0x0) and the
// kept limit (offset 0x8); write them only while no box is in work.
// The kept centers of the list are read one per cycle from the center RAM,
// its registered read feeds a three-stage distance and compare pipeline,
// and a hit stops the reads early. A box past the limit, or the first box
// of a list, skips the reads and goes straight to its result word.
// One box is in work at a time; s_tready is low from acceptance until
// its result is written to the output register.
// A stalled receiver keeps the result word in that register; the next box is
// still taken, but its result waits until the held word is read.
// Reset clears the count, the index, the threshold and the output valid, and sets the kept limit to 512.
// ----------------------------------------------------------------------------
module circle_nms_center_distance #(
    parameter int MAX_KEPT   = cnms_pkg::DEF_MAX_KEPT,
    parameter int MAX_BOXES  = cnms_pkg::DEF_MAX_BOXES,
    parameter int COORD_BITS = cnms_pkg::DEF_COORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cnms_pkg::S_TDATA_W-1:0] s_tdata,  // center_x[15:0], center_y[31:16]
    input  logic                           s_tlast,  // last_box
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cnms_pkg::M_TDATA_W-1:0] m_tdata,  // kept[0], box_index[12:1],
                                                     // kept_count[22:13], zero[23]
    output logic                           m_tlast,  // list_end
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cnms_pkg::APB_AW-1:0]    paddr,
    input  logic [cnms_pkg::APB_DW-1:0]    pwdata,
    output logic [cnms_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import cnms_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    logic [THRESH_W-1:0] thresh_reg;
    logic [MAXK_W-1:0]   maxk_reg;
    cnms_reg_t           reg_sel;
    logic                cfg_wr;

    logic [CW-1:0]       in_x, in_y;
    logic                rd_issue, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [CW-1:0]       box_x, box_y;
    logic [CW-1:0]       ram_x, ram_y;
    cnms_rsp_t           rsp;
    logic                out_kept;
    logic [INDEX_W-1:0]  out_index;
    logic [COUNT_W-1:0]  out_count;

    // Configuration registers.
    assign reg_sel = cnms_reg_t'(paddr[3]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= '0;
            maxk_reg   <= MAXK_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_THRESH: thresh_reg <= pwdata[THRESH_W-1:0];
                REG_MAXK:   maxk_reg   <= pwdata[MAXK_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_THRESH: prdata = APB_DW'(thresh_reg);
            REG_MAXK:   prdata = APB_DW'(maxk_reg);
            default:    prdata = '0;
        endcase
    end

    // Only the low COORD_BITS of each coordinate count; a wider COORD_BITS sign extends them.
    if (CW <= IN_COORD_W) begin : g_coord_trim
        assign in_x = s_tdata[CW-1:0];
        assign in_y = s_tdata[IN_COORD_W+CW-1:IN_COORD_W];
    end else begin : g_coord_ext
        assign in_x = {{(CW-IN_COORD_W){s_tdata[IN_COORD_W-1]}}, s_tdata[IN_COORD_W-1:0]};
        assign in_y = {{(CW-IN_COORD_W){s_tdata[S_TDATA_W-1]}},
                       s_tdata[S_TDATA_W-1:IN_COORD_W]};
    end

    cnms_ctrl #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES),
        .CW        (CW),
        .AW        (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_x      (in_x),
        .s_y      (in_y),
        .s_last   (s_tlast),
        .max_kept (maxk_reg),
        .rd_issue (rd_issue),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .box_x    (box_x),
        .box_y    (box_y),
        .rsp      (rsp),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_kept   (out_kept),
        .m_index  (out_index),
        .m_count  (out_count),
        .m_last   (m_tlast)
    );

    cnms_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_ram_x (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (box_x),
        .raddr (rd_addr),
        .rdata (ram_x)
    );

    cnms_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_ram_y (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (box_y),
        .raddr (rd_addr),
        .rdata (ram_y)
    );

    cnms_dist #(
        .CW (CW)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (rd_issue),
        .ram_x   (ram_x),
        .ram_y   (ram_y),
        .box_x   (box_x),
        .box_y   (box_y),
        .thresh  (thresh_reg),
        .rsp     (rsp)
    );

    assign m_tdata = {{(M_TDATA_W-1-INDEX_W-COUNT_W){1'b0}}, out_count, out_index, out_kept};

endmodule

// ===== rtl/core/cnms_ram.sv =====
// ----------------------------------------------------------------------------
// Circle NMS RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cnms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cnms_dist.sv =====
// ----------------------------------------------------------------------------
// Circle NMS distance unit
// Pipelined squared center distance and threshold compare, one kept center
// per cycle. Valid travels alongside the RAM read data.
// ----------------------------------------------------------------------------
module cnms_dist #(
    parameter int CW = cnms_pkg::DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          issue,
    input  logic [CW-1:0]                 ram_x,
    input  logic [CW-1:0]                 ram_y,
    input  logic [CW-1:0]                 box_x,
    input  logic [CW-1:0]                 box_y,
    input  logic [cnms_pkg::THRESH_W-1:0] thresh,
    output cnms_pkg::cnms_rsp_t           rsp
);
    import cnms_pkg::*;

    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;
    localparam int SW   = SQW + 1;
    localparam int CMPW = cnms_max(SW, THRESH_W);

    logic           v1_reg, v2_reg, v3_reg;
    logic [DW-1:0]  dx_reg, dy_reg;
    logic [DW-1:0]  dx_next, dy_next;
    logic [DW-1:0]  ax, ay;
    logic [SQW-1:0] sqx_reg, sqy_reg;
    logic [SQW-1:0] sqx_next, sqy_next;
    logic [SW-1:0]  sum;
    logic           hit_next;
    cnms_rsp_t      rsp_reg;

    // Differences are one bit wider than the coordinates, so they never wrap.
    assign dx_next = {ram_x[CW-1], ram_x} - {box_x[CW-1], box_x};
    assign dy_next = {ram_y[CW-1], ram_y} - {box_y[CW-1], box_y};

    // The magnitude of a DW-bit difference fits in DW unsigned bits.
    assign ax = dx_reg[DW-1] ? (~dx_reg + DW'(1)) : dx_reg;
    assign ay = dy_reg[DW-1] ? (~dy_reg + DW'(1)) : dy_reg;

    assign sqx_next = SQW'(ax) * SQW'(ax);
    assign sqy_next = SQW'(ay) * SQW'(ay);

    assign sum      = SW'(sqx_reg) + SW'(sqy_reg);
    assign hit_next = CMPW'(sum) <= CMPW'(thresh);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            rsp_reg.valid <= 1'b0;
        end else begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            rsp_reg.valid <= v3_reg;
        end
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        rsp_reg.hit <= hit_next;
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/cnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circle NMS sequencer
// Takes one box, walks the kept centers through the distance unit, decides,
// appends a kept center to the store and holds the result word.
// ----------------------------------------------------------------------------
module cnms_ctrl #(
    parameter int MAX_KEPT  = cnms_pkg::DEF_MAX_KEPT,
    parameter int MAX_BOXES = cnms_pkg::DEF_MAX_BOXES,
    parameter int CW        = cnms_pkg::DEF_COORD_BITS,
    parameter int AW        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [CW-1:0]                s_x,
    input  logic [CW-1:0]                s_y,
    input  logic                         s_last,
    input  logic [cnms_pkg::MAXK_W-1:0]  max_kept,
    output logic                         rd_issue,
    output logic [AW-1:0]                rd_addr,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [CW-1:0]                box_x,
    output logic [CW-1:0]                box_y,
    input  cnms_pkg::cnms_rsp_t          rsp,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kept,
    output logic [cnms_pkg::INDEX_W-1:0] m_index,
    output logic [cnms_pkg::COUNT_W-1:0] m_count,
    output logic                         m_last
);
    import cnms_pkg::*;

    localparam int KW      = $clog2(MAX_KEPT + 1);
    localparam int IDX_LIM = cnms_min(MAX_BOXES - 1, INDEX_FIELD_MAX);
    localparam int PW      = cnms_max($clog2(IDX_LIM + 1), 1);
    localparam int LW      = cnms_max(KW, MAXK_W);
    localparam int CXW     = cnms_max(KW, COUNT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       box_x_reg, box_x_next;
    logic [CW-1:0]       box_y_reg, box_y_next;
    logic                last_reg, last_next;
    logic                keep_reg, keep_next;
    logic                hit_reg, hit_next;
    logic [KW-1:0]       total_reg, total_next;
    logic [KW-1:0]       iss_reg, iss_next;
    logic [KW-1:0]       rsp_reg, rsp_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_kept_reg, m_kept_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    logic [LW-1:0]       limit;
    logic                can_keep;
    logic [KW-1:0]       count_after;
    logic [CXW-1:0]      count_ext;

    // A limit above the store depth acts as the depth.
    assign limit = (LW'(max_kept) < LW'(MAX_KEPT)) ? LW'(max_kept) : LW'(MAX_KEPT);
    assign can_keep = LW'(total_reg) < limit;

    // The total stays below the limit while a box is kept, so the increment fits.
    assign count_after = keep_reg ? (total_reg + KW'(1)) : total_reg;
    assign count_ext   = CXW'(count_after);

    always_comb begin
        state_next   = state_reg;
        box_x_next   = box_x_reg;
        box_y_next   = box_y_reg;
        last_next    = last_reg;
        keep_next    = keep_reg;
        hit_next     = hit_reg;
        total_next   = total_reg;
        iss_next     = iss_reg;
        rsp_next     = rsp_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_kept_next  = m_kept_reg;
        m_index_next = m_index_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        rd_issue     = 1'b0;
        wr_en        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    box_x_next = s_x;
                    box_y_next = s_y;
                    last_next  = s_last;
                    iss_next   = '0;
                    rsp_next   = '0;
                    hit_next   = 1'b0;
                    if (!can_keep) begin
                        keep_next  = 1'b0;
                        state_next = ST_DONE;
                    end else if (total_reg == '0) begin
                        keep_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Reads stop at the first hit; reads already in flight drain.
                if (!hit_reg && iss_reg != total_reg) begin
                    rd_issue = 1'b1;
                    iss_next = iss_reg + KW'(1);
                end
                if (rsp.valid) begin
                    rsp_next = rsp_reg + KW'(1);
                    if (rsp.hit) begin
                        hit_next = 1'b1;
                    end
                end
                if (iss_reg == rsp_reg && (hit_reg || iss_reg == total_reg)) begin
                    keep_next  = !hit_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kept_next  = keep_reg;
                    m_index_next = INDEX_W'(pos_reg);
                    m_count_next = count_ext[COUNT_W-1:0];
                    m_last_next  = last_reg;
                    wr_en        = keep_reg;
                    if (last_reg) begin
                        total_next = '0;
                        pos_next   = '0;
                    end else begin
                        total_next = count_after;
                        if (pos_reg < PW'(IDX_LIM)) begin
                            pos_next = pos_reg + PW'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            pos_reg     <= '0;
            iss_reg     <= '0;
            rsp_reg     <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            iss_reg     <= iss_next;
            rsp_reg     <= rsp_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
        box_x_reg   <= box_x_next;
        box_y_reg   <= box_y_next;
        last_reg    <= last_next;
        keep_reg    <= keep_next;
        m_kept_reg  <= m_kept_next;
        m_index_reg <= m_index_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign rd_addr = iss_reg[AW-1:0];
    assign wr_addr = total_reg[AW-1:0];
    assign box_x   = box_x_reg;
    assign box_y   = box_y_reg;
    assign m_valid = m_valid_reg;
    assign m_kept  = m_kept_reg;
    assign m_index = m_index_reg;
    assign m_count = m_count_reg;
    assign m_last  = m_last_reg;

endmodule

// ===== rtl/core/circle_nms_center_distance_chk.sv =====
// ----------------------------------------------------------------------------
// Circle NMS port checker
// Watches the stream ports of the circle NMS block over time.
// ----------------------------------------------------------------------------
`include "circle_nms_center_distance_macros.svh"

module circle_nms_center_distance_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cnms_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import cnms_pkg::*;

    // The output register is empty after reset.
    `CNMS_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_tvalid, "output valid after reset")

    // A box is worked on alone: the input closes right after a word is taken.
    `CNMS_ASSERT_NXT(a_one_box, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input ready while a box is in work")

    // A kept box always counts itself.
    `CNMS_ASSERT_IMP(a_kept_count, aclk, aresetn, m_tvalid && m_tdata[0],
        m_tdata[INDEX_W+COUNT_W:INDEX_W+1] != '0, "kept box with zero kept count")

    // A stalled result word holds.
    `CNMS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result word changed")

endmodule

bind circle_nms_center_distance circle_nms_center_distance_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
